// File: design/sdq_pkg.sv
package sdq_pkg;

  // Width of a stored thread id (the id field of a result is 8 bits)
  localparam int ID_W = 8;
  localparam int TICK_W = 64;
  localparam int DUR_W = 32;

  // Result status codes
  typedef enum logic [1:0] {
    ST_QUEUED = 2'd0,
    ST_FULL   = 2'd1,
    ST_WOKEN  = 2'd2,
    ST_NONE   = 2'd3
  } status_t;

  // Request kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_SLEEP = 1'b1;

  // One queue slot
  typedef struct packed {
    logic              valid;
    logic [TICK_W-1:0] wake;
    logic [ID_W-1:0]   id;
  } entry_t;

  // Queue operation, broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } ctl_t;

endpackage

// File: design/sdq_cell.sv
module sdq_cell (
  input  logic            clk,
  input  logic            rst,
  input  sdq_pkg::ctl_t   ctl,
  input  sdq_pkg::entry_t new_entry,
  input  sdq_pkg::entry_t left,
  input  sdq_pkg::entry_t right,
  input  logic            left_gt,
  output logic            gt,
  output sdq_pkg::entry_t entry
);

  // Slot is empty or wakes strictly later than the new entry
  assign gt = !entry.valid || (entry.wake > new_entry.wake);

  // Pop shifts toward the head; insert shifts later entries away from it
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (ctl.pop) begin
      entry <= right;
    end else if (ctl.ins && gt) begin
      entry <= left_gt ? left : new_entry;
    end
  end

endmodule

// File: design/sleep_deadline_queue.sv
// Sleep deadline queue: 64-bit tick counter plus a queue of sleeping threads
// ordered by wake time, held in a chain of cells (head is cell 0).
// Input channel (in_valid/in_ready): kind 0 is a timer tick, kind 1 a sleep
// request carrying thread_id and duration_ms.
// Output channel (out_valid/out_ready): status, woken_id, tick_now, last.
// A sleep request: the wake time is added at accept, and once the output
// register is free it is compared against every cell at once, inserted, and
// the single result is loaded. A request to a full queue is rejected.
// A tick bumps the counter at accept, then delivers one result per cycle
// from the head cell while the receiver keeps up: one for each woken thread,
// or a single "nothing due" result. The last result of a request has last set.
// Results pass through one output register; the next request is taken
// while the final result still waits there. When the receiver stalls, the
// result register holds and the tick scan waits.
// Reset clears the counter and empties the queue.
module sleep_deadline_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  thread_id,
  input  logic [31:0] duration_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  woken_id,
  output logic [63:0] tick_now,
  output logic        last
);

  localparam int IdKeep = (ID_BITS < sdq_pkg::ID_W) ? ID_BITS : sdq_pkg::ID_W;
  localparam logic [sdq_pkg::ID_W-1:0] IdMask = sdq_pkg::ID_W'((1 << IdKeep) - 1);

  typedef enum logic [1:0] {IDLE, SLEEP, TICK} state_t;

  state_t                     state;
  logic [sdq_pkg::TICK_W-1:0] tick_count;
  sdq_pkg::entry_t            req;
  sdq_pkg::status_t           status_q;

  sdq_pkg::entry_t            cells [QUEUE_DEPTH];
  logic                       gts   [QUEUE_DEPTH];
  sdq_pkg::ctl_t              ctl;

  logic in_fire;
  logic out_free;
  logic load_out;
  logic full;
  logic due0;
  logic due1;

  assign in_ready = (state == IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign load_out = ((state == SLEEP) || (state == TICK)) && out_free;
  assign full     = cells[QUEUE_DEPTH-1].valid;
  assign due0     = cells[0].valid && (cells[0].wake <= tick_count);
  assign status   = status_q;

  generate
    if (QUEUE_DEPTH > 1) begin : g_due1
      assign due1 = cells[1].valid && (cells[1].wake <= tick_count);
    end else begin : g_no_due1
      assign due1 = 1'b0;
    end
  endgenerate

  // Queue operations for this cycle
  always_comb begin
    ctl.ins = (state == SLEEP) && out_free && !full;
    ctl.pop = (state == TICK) && out_free && due0;
  end

  // Chain of cells
  generate
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      sdq_pkg::entry_t left_e;
      sdq_pkg::entry_t right_e;
      logic            left_g;
      if (i == 0) begin : g_head
        assign left_e = '0;
        assign left_g = 1'b0;
      end else begin : g_mid
        assign left_e = cells[i-1];
        assign left_g = gts[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign right_e = '0;
      end else begin : g_body
        assign right_e = cells[i+1];
      end
      sdq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .new_entry (req),
        .left      (left_e),
        .right     (right_e),
        .left_gt   (left_g),
        .gt        (gts[i]),
        .entry     (cells[i])
      );
    end
  endgenerate

  // Control, counter, request capture and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      tick_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Result valid: set on a load, cleared once taken
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_fire) begin
            req.valid <= 1'b1;
            req.wake  <= tick_count + sdq_pkg::TICK_W'(duration_ms);
            req.id    <= thread_id & IdMask;
            if (kind == sdq_pkg::KIND_SLEEP) begin
              state <= SLEEP;
            end else begin
              tick_count <= tick_count + sdq_pkg::TICK_W'(1);
              state      <= TICK;
            end
          end
        end
        SLEEP: begin
          if (out_free) begin
            status_q  <= full ? sdq_pkg::ST_FULL : sdq_pkg::ST_QUEUED;
            woken_id  <= req.id;
            tick_now  <= tick_count;
            last      <= 1'b1;
            state     <= IDLE;
          end
        end
        TICK: begin
          if (out_free) begin
            tick_now  <= tick_count;
            if (due0) begin
              status_q <= sdq_pkg::ST_WOKEN;
              woken_id <= cells[0].id;
              last     <= !due1;
              if (!due1) begin
                state <= IDLE;
              end
            end else begin
              // only reached on the first scan step: nothing due
              status_q <= sdq_pkg::ST_NONE;
              woken_id <= '0;
              last     <= 1'b1;
              state    <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
